// ===== rtl/tdor_pkg.sv =====
// shared constants and codes for the torus dimension-order router
// no dependencies
`default_nettype none

package tdor_pkg;

    localparam int COORD_BITS_DEF = 4;
    localparam int STAMP_BITS_DEF = 32;
    localparam int TAG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int NUM_RES        = 4;
    localparam int NUM_PORTS      = 4;
    localparam int NUM_SLOTS      = 6;

    localparam logic CMD_RECV = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_RECV = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    localparam logic [1:0] PORT_X     = 2'd0;
    localparam logic [1:0] PORT_Y     = 2'd1;
    localparam logic [1:0] PORT_Z     = 2'd2;
    localparam logic [1:0] PORT_CHILD = 2'd3;

    localparam logic [1:0] SRC_CHILD = 2'd0;

    localparam logic [CFG_IDX_BITS-1:0] REG_NODE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODE_Z = 2'd2;

    // route match bits: M* must match this node, N* must differ
    localparam logic [5:0] M_MX = 6'h01;
    localparam logic [5:0] M_MY = 6'h02;
    localparam logic [5:0] M_MZ = 6'h04;
    localparam logic [5:0] M_NX = 6'h08;
    localparam logic [5:0] M_NY = 6'h10;
    localparam logic [5:0] M_NZ = 6'h20;

    localparam logic [5:0] ROUTE_MATCH [NUM_PORTS] = '{
        M_NX,
        M_NY | M_MX,
        M_NZ | M_MX | M_MY,
        M_MX | M_MY | M_MZ
    };

endpackage

`default_nettype wire

// ===== rtl/tdor_if.sv =====
// valid/ready channel interfaces for the router: request, response, config
// depends on tdor_pkg
`default_nettype none

interface tdor_req_if
    import tdor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [1:0]            src_port;
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;
    logic [COORD_BITS-1:0] dst_z;
    logic                  vc_flag;
    logic [STAMP_BITS-1:0] timestamp;
    logic [TAG_BITS-1:0]   packet_tag;
    logic [3:0]            ready_mask;

    modport source (
        output valid, cmd, src_port, dst_x, dst_y, dst_z, vc_flag, timestamp,
               packet_tag, ready_mask,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_port, dst_x, dst_y, dst_z, vc_flag, timestamp,
               packet_tag, ready_mask,
        output ready
    );
endinterface

interface tdor_rsp_if
    import tdor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic                  accepted;
    logic [1:0]            out_port;
    logic [COORD_BITS-1:0] out_dst_x;
    logic [COORD_BITS-1:0] out_dst_y;
    logic [COORD_BITS-1:0] out_dst_z;
    logic                  out_vc_flag;
    logic [STAMP_BITS-1:0] out_timestamp;
    logic [TAG_BITS-1:0]   out_tag;
    logic                  last;

    modport source (
        output valid, kind, accepted, out_port, out_dst_x, out_dst_y, out_dst_z,
               out_vc_flag, out_timestamp, out_tag, last,
        input  ready
    );
    modport sink (
        input  valid, kind, accepted, out_port, out_dst_x, out_dst_y, out_dst_z,
               out_vc_flag, out_timestamp, out_tag, last,
        output ready
    );
endinterface

interface tdor_cfg_if
    import tdor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/torus_dimension_order_router_top.sv =====
// torus router node: holding registers, channel slots, oldest-first output pick
// an item is registered, then its results go into a four-entry result register;
// one item per cycle while that register is free, results leave one per cycle on ready
// a tick with several sends holds the input until its results drain to one
// reset (async, active low) clears all busy flags, priority channel and coordinates
// depends on tdor_pkg and tdor_if
`default_nettype none

module torus_dimension_order_router_top
    import tdor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdor_req_if.sink    req,
    tdor_rsp_if.source  rsp,
    tdor_cfg_if.sink    cfg
);

    typedef struct packed {
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [COORD_BITS-1:0] dz;
        logic                  vc;
        logic [STAMP_BITS-1:0] ts;
        logic [TAG_BITS-1:0]   tag;
    } pkt_t;

    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic [1:0] port;
        pkt_t       pkt;
        logic       last;
    } res_t;

    function automatic logic elig(input pkt_t s, input logic [5:0] m,
                                  input logic [COORD_BITS-1:0] nx,
                                  input logic [COORD_BITS-1:0] ny,
                                  input logic [COORD_BITS-1:0] nz);
        logic r;
        r = 1'b1;
        if (((m & M_MX) != '0) && (s.dx != nx)) r = 1'b0;
        if (((m & M_MY) != '0) && (s.dy != ny)) r = 1'b0;
        if (((m & M_MZ) != '0) && (s.dz != nz)) r = 1'b0;
        if (((m & M_NX) != '0) && (s.dx == nx)) r = 1'b0;
        if (((m & M_NY) != '0) && (s.dy == ny)) r = 1'b0;
        if (((m & M_NZ) != '0) && (s.dz == nz)) r = 1'b0;
        return r;
    endfunction

    logic [COORD_BITS-1:0] node_x_reg, node_y_reg, node_z_reg;

    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    logic [1:0] s1_src_reg;
    pkt_t       s1_pkt_reg;
    logic [3:0] s1_mask_reg;

    logic [NUM_PORTS-1:0] hold_busy_reg, hold_busy_next;
    pkt_t                 hold_reg [NUM_PORTS];
    pkt_t                 hold_next [NUM_PORTS];
    logic [NUM_SLOTS-1:0] slot_busy_reg, slot_busy_next;
    pkt_t                 slot_reg [NUM_SLOTS];
    pkt_t                 slot_next [NUM_SLOTS];
    logic                 prio_reg, prio_next;

    res_t       res_reg [NUM_RES];
    res_t       res_next [NUM_RES];
    logic [2:0] res_cnt_reg, res_cnt_next;

    res_t       res_list [NUM_RES];
    logic [2:0] n_res;

    logic out_fire;
    logic buf_free;
    logic s1_advance;

    assign out_fire   = (res_cnt_reg != 3'd0) && rsp.ready;
    assign buf_free   = (res_cnt_reg == 3'd0) || ((res_cnt_reg == 3'd1) && rsp.ready);
    assign s1_advance = s1_valid_reg && buf_free;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign cfg.ready  = 1'b1;

    // item processing
    always_comb
    begin
        logic [NUM_SLOTS-1:0] mv_busy;
        pkt_t                 mv_slot [NUM_SLOTS];
        logic [NUM_PORTS-1:0] mv_hold_busy;
        logic                 pc;
        logic                 prio_any;
        logic                 ch_sel;
        logic [2:0]           sidx;
        logic [3:0]           ok;
        logic [3:0]           win;
        pkt_t                 cand [4];
        logic [2:0]           cidx [3];
        res_t                 entry;

        hold_busy_next = hold_busy_reg;
        hold_next      = hold_reg;
        slot_busy_next = slot_busy_reg;
        slot_next      = slot_reg;
        prio_next      = prio_reg;
        n_res          = 3'd0;
        for (int k = 0; k < NUM_RES; k++)
        begin
            res_list[k] = '0;
        end
        mv_busy      = slot_busy_reg;
        mv_slot      = slot_reg;
        mv_hold_busy = hold_busy_reg;
        pc           = prio_reg;
        prio_any     = 1'b0;
        ch_sel       = 1'b0;
        sidx         = '0;
        ok           = '0;
        win          = '0;
        entry        = '0;
        for (int k = 0; k < 4; k++)
        begin
            cand[k] = '0;
        end
        for (int k = 0; k < 3; k++)
        begin
            cidx[k] = '0;
        end

        if (s1_advance)
        begin
            if (s1_cmd_reg == CMD_RECV)
            begin
                entry.kind = KIND_RECV;
                entry.last = 1'b1;
                if (!hold_busy_reg[s1_src_reg])
                begin
                    hold_busy_next[s1_src_reg] = 1'b1;
                    hold_next[s1_src_reg]      = s1_pkt_reg;
                    entry.accepted             = 1'b1;
                end
                res_list[0] = entry;
                n_res       = 3'd1;
            end
            else
            begin
                pc        = !prio_reg;
                prio_next = pc;

                // network holding registers into their channel slots
                for (int p = 0; p < 3; p++)
                begin
                    sidx = 3'(p * 2) + {2'b00, hold_reg[p + 1].vc};
                    if (mv_hold_busy[p + 1] && !mv_busy[sidx])
                    begin
                        mv_busy[sidx]        = 1'b1;
                        mv_slot[sidx]        = hold_reg[p + 1];
                        mv_hold_busy[p + 1]  = 1'b0;
                    end
                end
                slot_busy_next = mv_busy;
                slot_next      = mv_slot;
                hold_busy_next = mv_hold_busy;

                // port routes are disjoint, so each output picks independently
                for (int p = 0; p < NUM_PORTS; p++)
                begin
                    prio_any = 1'b0;
                    for (int c = 0; c < 3; c++)
                    begin
                        sidx = 3'(c * 2) + {2'b00, pc};
                        if (mv_busy[sidx] && (mv_slot[sidx].ts != '1)
                            && elig(mv_slot[sidx], ROUTE_MATCH[p],
                                    node_x_reg, node_y_reg, node_z_reg))
                        begin
                            prio_any = 1'b1;
                        end
                    end
                    ch_sel = prio_any ? pc : !pc;
                    for (int c = 0; c < 3; c++)
                    begin
                        cidx[c] = 3'(c * 2) + {2'b00, ch_sel};
                        cand[c] = mv_slot[cidx[c]];
                        ok[c]   = mv_busy[cidx[c]] && (mv_slot[cidx[c]].ts != '1)
                                  && elig(mv_slot[cidx[c]], ROUTE_MATCH[p],
                                          node_x_reg, node_y_reg, node_z_reg);
                    end
                    cand[3] = hold_reg[SRC_CHILD];
                    ok[3]   = mv_hold_busy[SRC_CHILD] && (hold_reg[SRC_CHILD].ts != '1)
                              && elig(hold_reg[SRC_CHILD], ROUTE_MATCH[p],
                                      node_x_reg, node_y_reg, node_z_reg);

                    // oldest stamp, first candidate wins ties
                    for (int k = 0; k < 4; k++)
                    begin
                        win[k] = ok[k];
                        for (int j = 0; j < 4; j++)
                        begin
                            if ((j < k) && ok[j] && (cand[j].ts <= cand[k].ts))
                            begin
                                win[k] = 1'b0;
                            end
                            if ((j > k) && ok[j] && (cand[j].ts < cand[k].ts))
                            begin
                                win[k] = 1'b0;
                            end
                        end
                    end

                    if ((win != '0) && s1_mask_reg[p])
                    begin
                        entry      = '0;
                        entry.kind = KIND_SEND;
                        entry.port = 2'(p);
                        for (int k = 0; k < 3; k++)
                        begin
                            if (win[k])
                            begin
                                entry.pkt                = cand[k];
                                slot_busy_next[cidx[k]]  = 1'b0;
                            end
                        end
                        if (win[3])
                        begin
                            entry.pkt                 = cand[3];
                            hold_busy_next[SRC_CHILD] = 1'b0;
                        end
                        res_list[n_res[1:0]] = entry;
                        n_res                = n_res + 3'd1;
                    end
                end
                if (n_res != 3'd0)
                begin
                    res_list[2'(n_res - 3'd1)].last = 1'b1;
                end
            end
        end
    end

    // result register
    always_comb
    begin
        res_next     = res_reg;
        res_cnt_next = res_cnt_reg;
        if (s1_advance)
        begin
            res_next     = res_list;
            res_cnt_next = n_res;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < NUM_RES - 1; k++)
            begin
                res_next[k] = res_reg[k + 1];
            end
            res_cnt_next = res_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hold_busy_reg <= '0;
            slot_busy_reg <= '0;
            prio_reg      <= 1'b0;
            res_cnt_reg   <= 3'd0;
            node_x_reg    <= '0;
            node_y_reg    <= '0;
            node_z_reg    <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            hold_busy_reg <= hold_busy_next;
            slot_busy_reg <= slot_busy_next;
            prio_reg      <= prio_next;
            res_cnt_reg   <= res_cnt_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_NODE_X: node_x_reg <= cfg.data;
                    REG_NODE_Y: node_y_reg <= cfg.data;
                    REG_NODE_Z: node_z_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg     <= req.cmd;
            s1_src_reg     <= req.src_port;
            s1_pkt_reg.dx  <= req.dst_x;
            s1_pkt_reg.dy  <= req.dst_y;
            s1_pkt_reg.dz  <= req.dst_z;
            s1_pkt_reg.vc  <= req.vc_flag;
            s1_pkt_reg.ts  <= req.timestamp;
            s1_pkt_reg.tag <= req.packet_tag;
            s1_mask_reg    <= req.ready_mask;
        end
        hold_reg <= hold_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    assign rsp.valid         = (res_cnt_reg != 3'd0);
    assign rsp.kind          = res_reg[0].kind;
    assign rsp.accepted      = res_reg[0].accepted;
    assign rsp.out_port      = res_reg[0].port;
    assign rsp.out_dst_x     = res_reg[0].pkt.dx;
    assign rsp.out_dst_y     = res_reg[0].pkt.dy;
    assign rsp.out_dst_z     = res_reg[0].pkt.dz;
    assign rsp.out_vc_flag   = res_reg[0].pkt.vc;
    assign rsp.out_timestamp = res_reg[0].pkt.ts;
    assign rsp.out_tag       = res_reg[0].pkt.tag;
    assign rsp.last          = res_reg[0].last;

endmodule

`default_nettype wire

// ===== rtl/tdor_checker.sv =====
// port-level assertions for the router top level, attached by bind
// depends on tdor_pkg and torus_dimension_order_router_top
`default_nettype none

module tdor_checker
    import tdor_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic                rsp_kind,
    input wire logic                rsp_accepted,
    input wire logic [1:0]          rsp_out_port,
    input wire logic [TAG_BITS-1:0] rsp_out_tag,
    input wire logic                rsp_last
);

    // stalled response stays valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // stalled response keeps its control fields
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_last)
                                    && $stable(rsp_out_port))
        else $error("response changed while stalled");

    // receive answer is always the only result of its item
    a_recv_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_RECV) |-> rsp_last)
        else $error("receive answer without last");

    // receive answer carries no packet
    a_recv_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_RECV) |-> (rsp_out_port == PORT_X)
                                                 && (rsp_out_tag == '0))
        else $error("receive answer carries packet fields");

    // send results never flag accepted
    a_send_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_SEND) |-> !rsp_accepted)
        else $error("send result flagged accepted");

endmodule

bind torus_dimension_order_router_top tdor_checker u_tdor_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_accepted (rsp.accepted),
    .rsp_out_port (rsp.out_port),
    .rsp_out_tag  (rsp.out_tag),
    .rsp_last     (rsp.last)
);

`default_nettype wire
